[hw/rtl/wildcard_pattern_matcher_macros.svh]
// Assertion helpers for the checker file.
`ifndef WILDCARD_PATTERN_MATCHER_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_MACROS_SVH

// Same-cycle implication, muted during reset.
`define WPM_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, muted during reset.
`define WPM_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[hw/rtl/wpm_pkg.sv]
package wpm_pkg;

   localparam logic [1:0] CMD_APPEND_PATTERN = 2'd0;
   localparam logic [1:0] CMD_APPEND_TEXT    = 2'd1;
   localparam logic [1:0] CMD_RUN            = 2'd2;

   localparam logic [7:0] SYM_ANY_ONE = 8'h3F;
   localparam logic [7:0] SYM_ANY_RUN = 8'h2A;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_START,
      OP_ADVANCE,
      OP_STAR,
      OP_TAIL,
      OP_BACKTRACK,
      OP_CLEAR
   } dp_op_type;

   typedef struct packed {
      logic      append_pattern;
      logic      append_text;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic overflow;
      logic pi_lt_plen;
      logic ti_lt_tlen;
      logic pi_last;
      logic p_star;
      logic p_hit;
      logic have_mark;
   } dp_status_type;

endpackage

[hw/rtl/wpm_ram.sv]
module wpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/wpm_datapath.sv]
module wpm_datapath #(
   parameter int MAX_PATTERN = 64,
   parameter int MAX_TEXT    = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             char_byte,
   input  wpm_pkg::dp_cmd_type    dp_cmd,
   output wpm_pkg::dp_status_type dp_status
);

   import wpm_pkg::*;

   localparam int PLW = $clog2(MAX_PATTERN + 1);
   localparam int TLW = $clog2(MAX_TEXT + 1);
   localparam int PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int TAW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

   logic [PLW-1:0] plen_ff, plen_in;
   logic [TLW-1:0] tlen_ff, tlen_in;
   logic           overflow_ff, overflow_in;
   logic [PLW-1:0] pi_ff, pi_in;
   logic [TLW-1:0] ti_ff, ti_in;
   logic [PLW-1:0] mark_p_ff, mark_p_in;
   logic [TLW-1:0] mark_t_ff, mark_t_in;
   logic           have_mark_ff, have_mark_in;

   logic           pat_room;
   logic           txt_room;
   logic           pat_wr;
   logic           txt_wr;
   logic [7:0]     p_data;
   logic [7:0]     t_data;
   logic [PLW-1:0] pi_plus;
   logic [TLW-1:0] ti_plus;
   logic [TLW-1:0] mark_t_plus;

   assign pat_room = plen_ff < PLW'(MAX_PATTERN);
   assign txt_room = tlen_ff < TLW'(MAX_TEXT);
   assign pat_wr   = dp_cmd.append_pattern & pat_room;
   assign txt_wr   = dp_cmd.append_text & txt_room;

   wpm_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_wr),
      .wr_addr (plen_ff[PAW-1:0]),
      .wr_data (char_byte),
      .rd_addr (pi_ff[PAW-1:0]),
      .rd_data (p_data)
   );

   wpm_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_text_ram (
      .clock   (clock),
      .wr_en   (txt_wr),
      .wr_addr (tlen_ff[TAW-1:0]),
      .wr_data (char_byte),
      .rd_addr (ti_ff[TAW-1:0]),
      .rd_data (t_data)
   );

   assign pi_plus     = pi_ff + PLW'(1);
   assign ti_plus     = ti_ff + TLW'(1);
   assign mark_t_plus = mark_t_ff + TLW'(1);

   always_comb begin
      plen_in      = plen_ff;
      tlen_in      = tlen_ff;
      overflow_in  = overflow_ff;
      pi_in        = pi_ff;
      ti_in        = ti_ff;
      mark_p_in    = mark_p_ff;
      mark_t_in    = mark_t_ff;
      have_mark_in = have_mark_ff;

      if (pat_wr) begin
         plen_in = plen_ff + PLW'(1);
      end
      if (txt_wr) begin
         tlen_in = tlen_ff + TLW'(1);
      end
      // drop the byte and flag it when the store is full
      if ((dp_cmd.append_pattern & ~pat_room) | (dp_cmd.append_text & ~txt_room)) begin
         overflow_in = 1'b1;
      end

      unique case (dp_cmd.op)
         OP_NONE: begin
         end
         OP_START: begin
            pi_in        = '0;
            ti_in        = '0;
            have_mark_in = 1'b0;
         end
         OP_ADVANCE: begin
            pi_in = pi_plus;
            ti_in = ti_plus;
         end
         OP_STAR: begin
            pi_in        = pi_plus;
            mark_p_in    = pi_plus;
            mark_t_in    = ti_ff;
            have_mark_in = 1'b1;
         end
         OP_TAIL: begin
            pi_in = pi_plus;
         end
         OP_BACKTRACK: begin
            mark_t_in = mark_t_plus;
            ti_in     = mark_t_plus;
            pi_in     = mark_p_ff;
         end
         OP_CLEAR: begin
            plen_in     = '0;
            tlen_in     = '0;
            overflow_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= '0;
         tlen_ff      <= '0;
         overflow_ff  <= 1'b0;
         have_mark_ff <= 1'b0;
      end else begin
         plen_ff      <= plen_in;
         tlen_ff      <= tlen_in;
         overflow_ff  <= overflow_in;
         have_mark_ff <= have_mark_in;
      end
      pi_ff     <= pi_in;
      ti_ff     <= ti_in;
      mark_p_ff <= mark_p_in;
      mark_t_ff <= mark_t_in;
   end

   assign dp_status.overflow   = overflow_ff;
   assign dp_status.pi_lt_plen = pi_ff < plen_ff;
   assign dp_status.ti_lt_tlen = ti_ff < tlen_ff;
   assign dp_status.pi_last    = pi_plus == plen_ff;
   assign dp_status.p_star     = p_data == SYM_ANY_RUN;
   assign dp_status.p_hit      = (p_data == SYM_ANY_ONE) || (p_data == t_data);
   assign dp_status.have_mark  = have_mark_ff;

endmodule

[hw/rtl/wpm_controller.sv]
module wpm_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_command,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_matched,
   output logic                   rsp_overflow,
   output wpm_pkg::dp_cmd_type    dp_cmd,
   input  wpm_pkg::dp_status_type dp_status
);

   import wpm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      match_ff, match_in;
   logic      rsp_valid_ff;
   logic      rsp_matched_ff;
   logic      rsp_overflow_ff;
   logic      slot_free;
   logic      accept;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in              = state_ff;
      match_in              = match_ff;
      dp_cmd.append_pattern = 1'b0;
      dp_cmd.append_text    = 1'b0;
      dp_cmd.op             = OP_NONE;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority case (req_command)
                  CMD_APPEND_PATTERN: dp_cmd.append_pattern = 1'b1;
                  CMD_APPEND_TEXT:    dp_cmd.append_text = 1'b1;
                  CMD_RUN: begin
                     if (dp_status.overflow) begin
                        match_in = 1'b0;
                        state_in = ST_FINISH;
                     end else begin
                        dp_cmd.op = OP_START;
                        state_in  = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_READ;
            if (dp_status.ti_lt_tlen) begin
               priority if (dp_status.pi_lt_plen && dp_status.p_star) begin
                  if (dp_status.pi_last) begin
                     match_in = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     dp_cmd.op = OP_STAR;
                  end
               end else if (dp_status.pi_lt_plen && dp_status.p_hit) begin
                  dp_cmd.op = OP_ADVANCE;
               end else if (dp_status.have_mark) begin
                  dp_cmd.op = OP_BACKTRACK;
               end else begin
                  match_in = 1'b0;
                  state_in = ST_FINISH;
               end
            end else begin
               priority if (!dp_status.pi_lt_plen) begin
                  match_in = 1'b1;
                  state_in = ST_FINISH;
               end else if (dp_status.p_star) begin
                  dp_cmd.op = OP_TAIL;
               end else begin
                  match_in = 1'b0;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               dp_cmd.op = OP_CLEAR;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_FINISH) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      match_ff <= match_in;
      if ((state_ff == ST_FINISH) && slot_free) begin
         rsp_matched_ff  <= match_ff;
         rsp_overflow_ff <= dp_status.overflow;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_matched  = rsp_matched_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

[hw/rtl/wildcard_pattern_matcher.sv]
// Channel  Direction  Signals                                   Beat
// req      in         req_valid/ready, req_command, req_char_byte  one command
// rsp      out        rsp_valid/ready, rsp_matched, rsp_overflow   one run result
//
// Append beats can follow back to back.
// A run beat walks both stores, each walk step a RAM read then a decide, and
// ends in the finish step; a run after overflow goes straight to finish.
// Walk steps grow with backtracking, up to roughly (text+1)*(pattern+1).
// Reset is synchronous and clears lengths, flag and control; the stores keep
// whatever they held. A stalled result holds in the output register while
// appends are taken; the next result waits in the finish step until it drains.
module wildcard_pattern_matcher #(
   parameter int MAX_PATTERN = 64,
   parameter int MAX_TEXT    = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [7:0] req_char_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic       rsp_overflow
);

   import wpm_pkg::*;

   // commands from the sequencer, flags back from the stores and pointers
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer: decode beats, run the greedy walk, own the result register
   wpm_controller u_controller (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_matched  (rsp_matched),
      .rsp_overflow (rsp_overflow),
      .dp_cmd       (dp_cmd),
      .dp_status    (dp_status)
   );

   // stores, lengths, overflow flag, walk pointers and backtrack mark
   wpm_datapath #(
      .MAX_PATTERN (MAX_PATTERN),
      .MAX_TEXT    (MAX_TEXT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .char_byte (req_char_byte),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

endmodule

[hw/rtl/wpm_checker.sv]
`include "wildcard_pattern_matcher_macros.svh"

module wpm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_command,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_matched,
   input logic       rsp_overflow
);

   import wpm_pkg::*;

   logic run_beat;
   logic append_beat;

   assign run_beat    = req_valid & req_ready & (req_command == CMD_RUN);
   assign append_beat = req_valid & req_ready &
                        ((req_command == CMD_APPEND_PATTERN) ||
                         (req_command == CMD_APPEND_TEXT));

   `WPM_ASSERT_NOW(a_overflow_no_match, clock, reset, rsp_valid && rsp_overflow,
      !rsp_matched, "overflow result reports a match")

   `WPM_ASSERT_NEXT(a_run_goes_busy, clock, reset, run_beat,
      !req_ready, "input still ready right after a run beat")

   `WPM_ASSERT_NEXT(a_append_stays_ready, clock, reset, append_beat,
      req_ready, "input not ready after an append beat")

   `WPM_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_matched) && $stable(rsp_overflow),
      "stalled result changed")

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (.*);
